// File: src/chained_hash_table_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CHT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define CHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/cht_pkg.sv
package cht_pkg;

   localparam int DEF_MAX_BUCKETS = 256;
   localparam int DEF_POOL_NODES  = 1024;
   localparam int DEF_KEY_BITS    = 32;

   localparam int CFG_W   = 9;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 11;
   localparam int DIV_W   = 10;

   localparam logic [CFG_W-1:0] BUCKET_RESET = 9'd256;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_HEAD,
      BK_WALK,
      BK_ALLOC,
      BK_FREE
   } back_state_type;

endpackage

// File: src/cht_fifo.sv
module cht_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push && !full);
      rd_ptr_in = rd_ptr_ff ^ (pop && !empty);
      count_in  = count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: src/cht_front.sv
module cht_front #(
   parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
   parameter int KEY_BITS    = cht_pkg::DEF_KEY_BITS,
   parameter int BW          = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    hold,
   output logic                    busy,
   input  cht_pkg::cmd_type        cmd,
   input  logic [cht_pkg::KEY_W-1:0] key,
   input  logic [cht_pkg::VAL_W-1:0] entry_value,
   input  logic [cht_pkg::CFG_W-1:0] bucket_count,
   input  logic                    q_full,
   output logic                    q_push,
   output cht_pkg::cmd_type        q_cmd,
   output logic [cht_pkg::KEY_W-1:0] q_key,
   output logic [cht_pkg::VAL_W-1:0] q_value,
   output logic [BW-1:0]           q_bucket
);
   import cht_pkg::*;

   localparam int KB  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int CW  = (KB > 1) ? $clog2(KB) : 1;
   localparam int SW  = CFG_W + 8;

   front_state_type state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]    step_ff, step_in;
   logic [DIV_W-1:0] rem_sh;
   logic [KEY_W-1:0] key_mask;
   logic [DIV_W-1:0] div_sat;

   always_comb begin
      key_mask = (KB >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KB) - KEY_W'(1));
      if (bucket_count == '0) begin
         div_sat = DIV_W'(1);
      end else if (SW'(bucket_count) > SW'(MAX_BUCKETS)) begin
         div_sat = DIV_W'(MAX_BUCKETS);
      end else begin
         div_sat = DIV_W'(bucket_count);
      end
   end

   assign busy     = (state_ff != FR_IDLE) || hold;
   assign q_cmd    = cmd_ff;
   assign q_key    = key_ff;
   assign q_value  = value_ff;
   assign q_bucket = BW'(rem_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      shift_in = shift_ff;
      value_in = value_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      q_push   = 1'b0;
      rem_sh   = {rem_ff[DIV_W-2:0], shift_ff[KB-1]};
      unique case (state_ff)
         FR_IDLE: begin
            if (start && !hold) begin
               cmd_in   = cmd;
               key_in   = key & key_mask;
               shift_in = key & key_mask;
               value_in = entry_value;
               div_in   = div_sat;
               rem_in   = '0;
               step_in  = '0;
               state_in = FR_DIVIDE;
            end
         end
         FR_DIVIDE: begin
            rem_in   = (rem_sh >= div_ff) ? (rem_sh - div_ff) : rem_sh;
            shift_in = shift_ff << 1;
            step_in  = step_ff + CW'(1);
            if (step_ff == CW'(KB - 1)) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      shift_ff <= shift_in;
      value_ff <= value_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end
endmodule

// File: src/cht_back.sv
module cht_back #(
   parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
   parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES,
   parameter int BW          = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   output logic                      q_pop,
   input  cht_pkg::cmd_type          q_cmd,
   input  logic [cht_pkg::KEY_W-1:0] q_key,
   input  logic [cht_pkg::VAL_W-1:0] q_value,
   input  logic [BW-1:0]             q_bucket,
   output logic                      clearing,
   output logic                      rsp_strobe,
   output logic                      rsp_hit,
   output logic [cht_pkg::VAL_W-1:0] rsp_found_value,
   output logic                      rsp_status,
   output logic [cht_pkg::COUNT_W-1:0] rsp_stored_count
);
   import cht_pkg::*;

   localparam int NW  = $clog2(POOL_NODES + 1);
   localparam int NIW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

   logic [NW-1:0]    head_mem [MAX_BUCKETS];
   logic [KEY_W-1:0] key_mem  [POOL_NODES];
   logic [VAL_W-1:0] data_mem [POOL_NODES];
   logic [NW-1:0]    link_mem [POOL_NODES];

   logic [NW-1:0]    head_rd_ff;
   logic [KEY_W-1:0] key_rd_ff;
   logic [VAL_W-1:0] data_rd_ff;
   logic [NW-1:0]    link_rd_ff;

   logic [BW-1:0]    head_raddr, head_waddr;
   logic             head_we;
   logic [NW-1:0]    head_wdata;
   logic [NW-1:0]    node_raddr;
   logic             node_we;
   logic [NW-1:0]    node_waddr;
   logic             link_we;
   logic [NW-1:0]    link_waddr, link_wdata;

   back_state_type   state_ff, state_in;
   logic [BW-1:0]    clr_ff, clr_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   logic [NW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    prev_ff, prev_in;
   logic [NW-1:0]    free_head_ff, free_head_in;
   logic [NW-1:0]    fresh_ff, fresh_in;
   logic [NW-1:0]    total_ff, total_in;
   logic [NW-1:0]    alloc_node;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [NW-1:0]    rsp_count_ff, rsp_count_in;

   assign clearing         = (state_ff == BK_CLEAR);
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_value  = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_count = COUNT_W'(rsp_count_ff);
   assign alloc_node       = (free_head_ff != NIL) ? free_head_ff : fresh_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      bkt_in        = bkt_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = 1'b0;
      rsp_count_in  = total_ff;
      q_pop         = 1'b0;
      head_raddr    = bkt_ff;
      head_we       = 1'b0;
      head_waddr    = bkt_ff;
      head_wdata    = NIL;
      node_raddr    = cur_ff;
      node_we       = 1'b0;
      node_waddr    = alloc_node;
      link_we       = 1'b0;
      link_waddr    = alloc_node;
      link_wdata    = head_rd_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               cmd_in     = q_cmd;
               key_in     = q_key;
               value_in   = q_value;
               bkt_in     = q_bucket;
               head_raddr = q_bucket;
               prev_in    = NIL;
               state_in   = BK_HEAD;
            end
         end
         BK_HEAD: begin
            unique case (cmd_ff) inside
               CMD_INSERT: begin
                  if (total_ff == NW'(POOL_NODES)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                     state_in      = BK_IDLE;
                  end else begin
                     node_we    = 1'b1;
                     link_we    = 1'b1;
                     head_we    = 1'b1;
                     head_wdata = alloc_node;
                     node_raddr = alloc_node;
                     total_in   = total_ff + NW'(1);
                     if (free_head_ff != NIL) begin
                        state_in = BK_ALLOC;
                     end else begin
                        fresh_in     = fresh_ff + NW'(1);
                        rsp_valid_in = 1'b1;
                        rsp_count_in = total_ff + NW'(1);
                        state_in     = BK_IDLE;
                     end
                  end
               end
               CMD_REMOVE, CMD_FIND: begin
                  if (head_rd_ff == NIL) begin
                     rsp_valid_in = 1'b1;
                     state_in     = BK_IDLE;
                  end else begin
                     cur_in     = head_rd_ff;
                     node_raddr = head_rd_ff;
                     state_in   = BK_WALK;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = BK_IDLE;
               end
            endcase
         end
         BK_WALK: begin
            if (key_rd_ff == key_ff) begin
               if (cmd_ff == CMD_FIND) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b1;
                  rsp_value_in = data_rd_ff;
                  state_in     = BK_IDLE;
               end else begin
                  if (prev_ff == NIL) begin
                     head_we    = 1'b1;
                     head_wdata = link_rd_ff;
                  end else begin
                     link_we    = 1'b1;
                     link_waddr = prev_ff;
                     link_wdata = link_rd_ff;
                  end
                  total_in = total_ff - NW'(1);
                  state_in = BK_FREE;
               end
            end else if (link_rd_ff == NIL) begin
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end else begin
               prev_in    = cur_ff;
               cur_in     = link_rd_ff;
               node_raddr = link_rd_ff;
            end
         end
         BK_FREE: begin
            link_we      = 1'b1;
            link_waddr   = cur_ff;
            link_wdata   = free_head_ff;
            free_head_in = cur_ff;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 1'b1;
            state_in     = BK_IDLE;
         end
         BK_ALLOC: begin
            free_head_in = link_rd_ff;
            rsp_valid_in = 1'b1;
            state_in     = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clr_ff        <= '0;
         free_head_ff  <= NIL;
         fresh_ff      <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         fresh_ff      <= fresh_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      bkt_ff        <= bkt_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[head_raddr];
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[node_raddr[NIW-1:0]];
      data_rd_ff <= data_mem[node_raddr[NIW-1:0]];
      link_rd_ff <= link_mem[node_raddr[NIW-1:0]];
      if (node_we) begin
         key_mem[node_waddr[NIW-1:0]]  <= key_ff;
         data_mem[node_waddr[NIW-1:0]] <= value_ff;
      end
      if (link_we) begin
         link_mem[link_waddr[NIW-1:0]] <= link_wdata;
      end
   end
endmodule

// File: src/chained_hash_table_top.sv
// Channel   Ports                                     Handshake
// request   req_command, req_key, req_entry_value     start high, busy low
// response  rsp_hit, rsp_found_value, rsp_status,     rsp_strobe, one cycle
//           rsp_stored_count
// config    csr_wdata                                 csr_we
//
// A beat is accepted when start is high and busy is low; busy then stays high while
// the bit-serial remainder unit forms the bucket and the beat is pushed to the queue,
// and longer while the two-entry queue to the back end is full.
// The back end takes a beat and reads its bucket head, walks the chain node by node,
// and adds a free or alloc step on a remove hit or on an insert that reuses a freed node.
// After reset every bucket head is cleared while busy is held high.
// The receiver cannot stall: each response is shown for exactly one cycle.
module chained_hash_table_top #(
   parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
   parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES,
   parameter int KEY_BITS    = cht_pkg::DEF_KEY_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  logic [cht_pkg::KEY_W-1:0]   req_key,
   input  logic [cht_pkg::VAL_W-1:0]   req_entry_value,
   input  logic                        csr_we,
   input  logic [cht_pkg::CFG_W-1:0]   csr_wdata,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic [cht_pkg::VAL_W-1:0]   rsp_found_value,
   output logic                        rsp_status,
   output logic [cht_pkg::COUNT_W-1:0] rsp_stored_count
);
   import cht_pkg::*;

   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int QW = 2 + KEY_W + VAL_W + BW;

   logic [CFG_W-1:0] bucket_count_ff;
   logic             clearing;
   logic             q_push, q_pop, q_full, q_empty;
   cmd_type          f_cmd;
   logic [KEY_W-1:0] f_key;
   logic [VAL_W-1:0] f_value;
   logic [BW-1:0]    f_bucket;
   logic [QW-1:0]    q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_RESET;
      end else if (csr_we) begin
         bucket_count_ff <= csr_wdata;
      end
   end

   cht_front #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .KEY_BITS(KEY_BITS),
      .BW(BW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .hold(clearing),
      .busy(busy),
      .cmd(cmd_type'(req_command)),
      .key(req_key),
      .entry_value(req_entry_value),
      .bucket_count(bucket_count_ff),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(f_cmd),
      .q_key(f_key),
      .q_value(f_value),
      .q_bucket(f_bucket)
   );

   cht_fifo #(
      .WIDTH(QW)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data({f_cmd, f_key, f_value, f_bucket}),
      .pop(q_pop),
      .pop_data(q_out),
      .full(q_full),
      .empty(q_empty)
   );

   cht_back #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .POOL_NODES(POOL_NODES),
      .BW(BW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .q_cmd(cmd_type'(q_out[QW-1 -: 2])),
      .q_key(q_out[QW-3 -: KEY_W]),
      .q_value(q_out[BW+VAL_W-1 -: VAL_W]),
      .q_bucket(q_out[BW-1:0]),
      .clearing(clearing),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_found_value(rsp_found_value),
      .rsp_status(rsp_status),
      .rsp_stored_count(rsp_stored_count)
   );
endmodule

// File: src/cht_checker.sv
`include "chained_hash_table_top_assert.svh"

module cht_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic                        rsp_hit,
   input logic [cht_pkg::VAL_W-1:0]   rsp_found_value,
   input logic                        rsp_status
);
   `CHT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CHT_ASSERT_SAME(a_drop_no_hit, clock, reset, rsp_strobe && rsp_status, !rsp_hit)
   `CHT_ASSERT_SAME(a_miss_zero, clock, reset, rsp_strobe && !rsp_hit, rsp_found_value == '0)
   `CHT_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
endmodule

bind chained_hash_table_top cht_checker u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_hit(rsp_hit),
   .rsp_found_value(rsp_found_value),
   .rsp_status(rsp_status)
);
